FILE: src/rle_pkg.sv
// shared types, constants and helpers for the literal-run encoder
// no dependencies
package rle_pkg;

  localparam int MAX_RUN     = 127;
  localparam int MAX_LITERAL = 61;
  localparam int RUN_W       = $clog2(MAX_RUN + 1);
  localparam int LIT_W       = $clog2(MAX_LITERAL + 1);
  localparam int CNT_W       = (RUN_W > LIT_W) ? RUN_W : LIT_W;
  localparam int FIFO_DEPTH  = 2;
  localparam int PTR_W       = $clog2(FIFO_DEPTH);

  typedef enum logic {
    CMD_RUN,
    CMD_LIT
  } cmd_kind_t;

  // run: len = run length, data = run byte
  // literal group: len = bytes held in the buffer, data = tail byte when tail is set
  typedef struct packed {
    cmd_kind_t        kind;
    logic [CNT_W-1:0] len;
    logic [7:0]       data;
    logic             tail;
    logic             last;
  } cmd_t;

  typedef struct packed {
    cmd_t c0;
    cmd_t c1;
    logic has_c1;
    logic uses_buf;
  } pkt_t;

  typedef struct packed {
    logic             we;
    logic [LIT_W-1:0] addr;
    logic [7:0]       data;
  } buf_wr_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_HDR,
    BK_DATA
  } bk_state_t;

  function automatic cmd_t mk_run(input logic [RUN_W-1:0] len, input logic [7:0] b);
    cmd_t c;
    c.kind = CMD_RUN;
    c.len  = CNT_W'(len);
    c.data = b;
    c.tail = 1'b0;
    c.last = 1'b0;
    return c;
  endfunction

  function automatic cmd_t mk_lit(input logic [LIT_W-1:0] cnt, input logic tv,
                                  input logic [7:0] b);
    cmd_t c;
    c.kind = CMD_LIT;
    c.len  = CNT_W'(cnt);
    c.data = b;
    c.tail = tv;
    c.last = 1'b0;
    return c;
  endfunction

endpackage

FILE: src/rle_literal_run_encoder_top.sv
// top level of the literal-run byte encoder: front end, command queue, back end
// depends on rle_pkg, rle_front, rle_cmd_fifo, rle_back
// with the back end idle, the first result byte passes the queue, the idle and header states and the output register
// 1 input byte per cycle while the queue is not full and no literal group holds the buffer;
// the back end pops only from idle; a buffered literal group stalls input until its packet ends
// reset: synchronous, clears run state, queue and output valid; literal buffer not cleared
module rle_literal_run_encoder_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       last_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       is_header,
  output logic       last_out
);
  import rle_pkg::*;

  logic    push;
  pkt_t    push_pkt;
  logic    fifo_full;
  logic    f_valid;
  pkt_t    f_pkt;
  logic    pop;
  buf_wr_t buf_wr;
  logic    buf_release;

  rle_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .last_in     (last_in),
    .fifo_full   (fifo_full),
    .push        (push),
    .push_pkt    (push_pkt),
    .buf_wr      (buf_wr),
    .buf_release (buf_release)
  );

  rle_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_pkt (push_pkt),
    .full     (fifo_full),
    .valid    (f_valid),
    .pkt      (f_pkt),
    .pop      (pop)
  );

  rle_back u_back (
    .clk         (clk),
    .rst         (rst),
    .f_valid     (f_valid),
    .f_pkt       (f_pkt),
    .pop         (pop),
    .buf_wr      (buf_wr),
    .buf_release (buf_release),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .is_header   (is_header),
    .last_out    (last_out)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !fifo_full)
    else $error("command pushed into full queue");

  a_last_is_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_out) |-> !is_header)
    else $error("final byte of block marked as header");

  a_no_write_on_release: assert property (@(posedge clk) disable iff (rst)
    buf_release |-> !buf_wr.we)
    else $error("literal buffer written while a group is read out");

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

FILE: src/rle_front.sv
// front end: takes byte transfers, tracks the current run and literal count,
// writes literal bytes and queues run / literal-group commands; uses rle_pkg
module rle_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_byte,
  input  logic            last_in,
  input  logic            fifo_full,
  output logic            push,
  output rle_pkg::pkt_t   push_pkt,
  output rle_pkg::buf_wr_t buf_wr,
  input  logic            buf_release
);
  import rle_pkg::*;

  logic             have_prev, have_prev_next;
  logic [7:0]       prev_byte, prev_byte_next;
  logic [RUN_W-1:0] run_length, run_length_next;
  logic [LIT_W-1:0] lit_count, lit_count_next;
  logic             buf_busy;
  logic             acc;
  buf_wr_t          wr;
  pkt_t             pkt;

  assign in_stall = fifo_full || buf_busy;
  assign acc      = in_valid && !in_stall;

  always_comb begin
    cmd_t       c0, c1, cx;
    logic [1:0] n;
    c0 = '0;
    c1 = '0;
    cx = '0;
    n  = 2'd0;
    wr = '0;
    have_prev_next  = 1'b1;
    prev_byte_next  = prev_byte;
    run_length_next = run_length;
    lit_count_next  = lit_count;

    if (!have_prev) begin
      prev_byte_next  = in_byte;
      run_length_next = RUN_W'(1);
    end else if (in_byte == prev_byte) begin
      if (run_length >= RUN_W'(MAX_RUN)) begin
        cx = mk_run(run_length, prev_byte);
        if (n == 2'd0) c0 = cx; else c1 = cx;
        n = n + 2'd1;
        run_length_next = RUN_W'(1);
      end else begin
        if (run_length == RUN_W'(1) && lit_count != '0) begin
          cx = mk_lit(lit_count, 1'b0, 8'd0);
          if (n == 2'd0) c0 = cx; else c1 = cx;
          n = n + 2'd1;
          lit_count_next = '0;
        end
        run_length_next = run_length + RUN_W'(1);
      end
    end else begin
      if (run_length >= RUN_W'(2)) begin
        cx = mk_run(run_length, prev_byte);
        if (n == 2'd0) c0 = cx; else c1 = cx;
        n = n + 2'd1;
      end else begin
        wr.we   = 1'b1;
        wr.addr = lit_count;
        wr.data = prev_byte;
        if (lit_count == LIT_W'(MAX_LITERAL - 1)) begin
          cx = mk_lit(LIT_W'(MAX_LITERAL), 1'b0, 8'd0);
          if (n == 2'd0) c0 = cx; else c1 = cx;
          n = n + 2'd1;
          lit_count_next = '0;
        end else begin
          lit_count_next = lit_count + LIT_W'(1);
        end
      end
      prev_byte_next  = in_byte;
      run_length_next = RUN_W'(1);
    end

    if (last_in) begin
      if (run_length_next >= RUN_W'(2)) begin
        cx = mk_run(run_length_next, prev_byte_next);
        if (n == 2'd0) c0 = cx; else c1 = cx;
        n = n + 2'd1;
        if (lit_count_next != '0) begin
          cx = mk_lit(lit_count_next, 1'b0, 8'd0);
          if (n == 2'd0) c0 = cx; else c1 = cx;
          n = n + 2'd1;
        end
      end else begin
        // lone byte goes out as the tail of the group, no buffer write
        cx = mk_lit(lit_count_next, 1'b1, prev_byte_next);
        if (n == 2'd0) c0 = cx; else c1 = cx;
        n = n + 2'd1;
      end
      if (n == 2'd2) c1.last = 1'b1; else c0.last = 1'b1;
      have_prev_next  = 1'b0;
      prev_byte_next  = '0;
      run_length_next = '0;
      lit_count_next  = '0;
    end

    pkt.c0       = c0;
    pkt.c1       = c1;
    pkt.has_c1   = (n == 2'd2);
    pkt.uses_buf = (c0.kind == CMD_LIT && c0.len != '0) ||
                   (n == 2'd2 && c1.kind == CMD_LIT && c1.len != '0);
    push = acc && (n != 2'd0);
  end

  assign push_pkt = pkt;
  assign buf_wr   = '{we: wr.we && acc, addr: wr.addr, data: wr.data};

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev  <= 1'b0;
      prev_byte  <= '0;
      run_length <= '0;
      lit_count  <= '0;
      buf_busy   <= 1'b0;
    end else begin
      if (acc) begin
        have_prev  <= have_prev_next;
        prev_byte  <= prev_byte_next;
        run_length <= run_length_next;
        lit_count  <= lit_count_next;
      end
      if (push && pkt.uses_buf) begin
        buf_busy <= 1'b1;
      end else if (buf_release) begin
        buf_busy <= 1'b0;
      end
    end
  end

endmodule

FILE: src/rle_cmd_fifo.sv
// two-entry command queue between front and back end
// uses rle_pkg
module rle_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rle_pkg::pkt_t push_pkt,
  output logic          full,
  output logic          valid,
  output rle_pkg::pkt_t pkt,
  input  logic          pop
);
  import rle_pkg::*;

  pkt_t             slots [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full  = (count == (PTR_W + 1)'(FIFO_DEPTH));
  assign valid = (count != '0);
  assign pkt   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_pkt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop && valid) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + (PTR_W + 1)'(push && !full) - (PTR_W + 1)'(pop && valid);
    end
  end

endmodule

FILE: src/rle_back.sv
// back end: plays out queued commands as header and data bytes,
// holds the literal buffer and the output register; uses rle_pkg
module rle_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             f_valid,
  input  rle_pkg::pkt_t    f_pkt,
  output logic             pop,
  input  rle_pkg::buf_wr_t buf_wr,
  output logic             buf_release,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic             is_header,
  output logic             last_out
);
  import rle_pkg::*;

  logic [7:0]       mem [MAX_LITERAL];
  logic [7:0]       rd_data;
  logic [LIT_W-1:0] rd_addr;

  bk_state_t        state, state_next;
  pkt_t             pkt, pkt_next;
  logic             sel, sel_next;
  logic [LIT_W-1:0] idx, idx_next;

  cmd_t             cur;
  logic [LIT_W-1:0] k;
  logic [LIT_W-1:0] n_tot;
  logic             emit_ok;
  logic             e;
  logic [7:0]       e_byte;
  logic             e_hdr;
  logic             e_last;
  logic             cmd_end;

  assign cur     = sel ? pkt.c1 : pkt.c0;
  assign k       = cur.len[LIT_W-1:0];
  assign n_tot   = k + LIT_W'(cur.tail);
  assign emit_ok = !out_valid || !out_stall;

  always_comb begin
    state_next  = state;
    pkt_next    = pkt;
    sel_next    = sel;
    idx_next    = idx;
    pop         = 1'b0;
    e           = 1'b0;
    e_byte      = '0;
    e_hdr       = 1'b0;
    e_last      = 1'b0;
    cmd_end     = 1'b0;
    buf_release = 1'b0;

    unique case (state)
      BK_IDLE: begin
        if (f_valid) begin
          pop        = 1'b1;
          pkt_next   = f_pkt;
          sel_next   = 1'b0;
          idx_next   = '0;
          state_next = BK_HDR;
        end
      end
      BK_HDR: begin
        if (emit_ok) begin
          e     = 1'b1;
          e_hdr = 1'b1;
          if (cur.kind == CMD_RUN) begin
            e_byte = 8'(cur.len);
          end else if (n_tot == LIT_W'(1)) begin
            e_byte = 8'd1;
          end else begin
            e_byte = 8'd0 - 8'(n_tot);
          end
          state_next = BK_DATA;
        end
      end
      BK_DATA: begin
        if (emit_ok) begin
          e = 1'b1;
          if (cur.kind == CMD_RUN) begin
            e_byte  = cur.data;
            cmd_end = 1'b1;
          end else if (idx < k) begin
            e_byte   = rd_data;
            idx_next = idx + LIT_W'(1);
            cmd_end  = (idx + LIT_W'(1) == k) && !cur.tail;
          end else begin
            e_byte  = cur.data;
            cmd_end = 1'b1;
          end
          if (cmd_end) begin
            e_last = cur.last;
            if (!sel && pkt.has_c1) begin
              sel_next   = 1'b1;
              idx_next   = '0;
              state_next = BK_HDR;
            end else begin
              buf_release = pkt.uses_buf;
              state_next  = BK_IDLE;
            end
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  assign rd_addr = (idx_next < LIT_W'(MAX_LITERAL)) ? idx_next : '0;

  always_ff @(posedge clk) begin
    if (buf_wr.we) begin
      mem[buf_wr.addr] <= buf_wr.data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    pkt <= pkt_next;
    idx <= idx_next;
    if (e) begin
      out_byte  <= e_byte;
      is_header <= e_hdr;
      last_out  <= e_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      sel       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      sel   <= sel_next;
      if (e) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: tb/sv/rle_stream_check_pkg.sv
// expected-stream predictor and checker for the literal-run byte encoder testbench
// depends on rle_pkg for MAX_RUN and MAX_LITERAL
`timescale 1ns / 1ps
package rle_stream_check_pkg;
  import rle_pkg::*;

  typedef struct packed {
    logic [7:0] code;
    logic       hdr;
    logic       last;
  } enc_byte_t;

  class encoded_stream_predictor;
    logic [7:0] run_byte;
    logic       have_run;
    int         run_len;
    logic [7:0] lit_bytes [MAX_LITERAL];
    int         lit_cnt;
    enc_byte_t  encoded_due [$];
    int         mismatches;

    function new();
      clear_block();
      mismatches = 0;
    endfunction

    function void clear_block();
      have_run = 1'b0;
      run_byte = 8'h00;
      run_len  = 0;
      lit_cnt  = 0;
    endfunction

    function void push_code(input logic [7:0] code, input logic hdr);
      enc_byte_t e;
      e.code = code;
      e.hdr  = hdr;
      e.last = 1'b0;
      encoded_due.insert(encoded_due.size(), e);
    endfunction

    function void flush_literals();
      if (lit_cnt != 0) begin
        // one literal goes out as count 1, a group as minus its size
        push_code((lit_cnt == 1) ? 8'd1 : 8'(256 - lit_cnt), 1'b1);
        for (int i = 0; i < lit_cnt; i++) push_code(lit_bytes[i], 1'b0);
        lit_cnt = 0;
      end
    endfunction

    function void add_literal(input logic [7:0] b);
      lit_bytes[lit_cnt] = b;
      lit_cnt++;
      if (lit_cnt >= MAX_LITERAL) flush_literals();
    endfunction

    function void close_run();
      if (run_len >= 2) begin
        push_code(8'(run_len), 1'b1);
        push_code(run_byte, 1'b0);
      end else begin
        add_literal(run_byte);
      end
    endfunction

    // called once per input transfer
    function void note_raw_byte(input logic [7:0] b, input logic last);
      int        first_new;
      enc_byte_t e;
      first_new = encoded_due.size();
      if (!have_run) begin
        have_run = 1'b1;
        run_byte = b;
        run_len  = 1;
      end else if (b == run_byte) begin
        if (run_len >= MAX_RUN) begin
          push_code(8'(run_len), 1'b1);
          push_code(run_byte, 1'b0);
          run_len = 1;
        end else begin
          if (run_len == 1) flush_literals();
          run_len++;
        end
      end else begin
        close_run();
        run_byte = b;
        run_len  = 1;
      end
      if (last) begin
        close_run();
        flush_literals();
        clear_block();
        if (encoded_due.size() > first_new) begin
          e = encoded_due[encoded_due.size() - 1];
          e.last = 1'b1;
          encoded_due[encoded_due.size() - 1] = e;
        end
      end
    endfunction

    // called once per output transfer
    function void check_encoded_byte(input logic [7:0] code, input logic hdr,
                                     input logic last);
      enc_byte_t want;
      enc_byte_t got;
      got.code = code;
      got.hdr  = hdr;
      got.last = last;
      if (encoded_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected output transfer: out_byte %02h is_header %b last_out %b",
                 $time, code, hdr, last);
      end else begin
        want = encoded_due.pop_front();
        if (want !== got) begin
          mismatches++;
          $display("%0t: expected out_byte %02h is_header %b last_out %b, actual %02h %b %b",
                   $time, want.code, want.hdr, want.last, got.code, got.hdr, got.last);
        end
      end
    endfunction
  endclass

endpackage

FILE: tb/sv/rle_literal_run_encoder_top_tb.sv
// top-level testbench of the literal-run byte encoder: clock, reset, byte driver,
// output stall generator, transfer monitor and watchdog
// depends on rle_pkg, rle_stream_check_pkg and rle_literal_run_encoder_top
`timescale 1ns / 1ps
module rle_literal_run_encoder_top_tb;
  import rle_stream_check_pkg::*;

  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte   = 8'h00;
  logic       last_in   = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       is_header;
  logic       last_out;

  int idle_pct  = 0;
  int stall_pct = 0;
  int holds_asked  = 0;
  int holds_served = 0;
  int hold_left    = 0;

  logic [7:0] raw_block [$];
  encoded_stream_predictor pred;

  rle_literal_run_encoder_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .last_in   (last_in),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .is_header (is_header),
    .last_out  (last_out)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // receiver: random stall, or a long hold when one is asked for
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      out_stall    <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) pred.note_raw_byte(in_byte, last_in);
      if (out_valid && !out_stall) pred.check_encoded_byte(out_byte, is_header, last_out);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("FAIL rle_literal_run_encoder_top");
    $finish;
  end

  // returns in the time step of the transfer, with in_valid still high
  task automatic send_raw_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    last_in  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_outputs();
    in_valid <= 1'b0;
    while (pred.encoded_due.size() != 0) @(posedge clk);
  endtask

  task automatic send_raw_block();
    foreach (raw_block[i]) send_raw_byte(raw_block[i], i == raw_block.size() - 1);
  endtask

  // runs, literal stretches and small-alphabet noise, ended by the last mark
  function automatic void build_random_block();
    int         segs;
    int         kind;
    int         len;
    logic [7:0] b;
    raw_block.delete();
    b = 8'($urandom_range(255));
    segs = $urandom_range(1, 4);
    repeat (segs) begin
      kind = $urandom_range(9);
      len  = $urandom_range(1, 8);
      if (kind < 4) begin
        b = b + 8'($urandom_range(1, 255));
        repeat (len + 1) raw_block.insert(raw_block.size(), b);
      end else if (kind < 8) begin
        repeat (len) begin
          b = b + 8'($urandom_range(1, 255));
          raw_block.insert(raw_block.size(), b);
        end
      end else begin
        repeat (len) begin
          b = 8'($urandom_range(2)) | ($urandom_range(1) ? 8'hF0 : 8'h00);
          raw_block.insert(raw_block.size(), b);
        end
      end
    end
  endfunction

  task automatic send_random_blocks(input int budget);
    int sent;
    sent = 0;
    while (sent < budget) begin
      build_random_block();
      send_raw_block();
      sent += raw_block.size();
    end
  endtask

  initial begin
    logic [7:0] b;
    pred = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // single byte block, run of two at the extreme value
    send_raw_byte(8'h00, 1'b1);
    send_raw_byte(8'hFF, 1'b0);
    send_raw_byte(8'hFF, 1'b1);
    // lone literal flushed by a run, then a lone literal at the end
    send_raw_byte(8'h12, 1'b0);
    send_raw_byte(8'h34, 1'b0);
    send_raw_byte(8'h34, 1'b0);
    send_raw_byte(8'h56, 1'b1);
    // literal group
    send_raw_byte(8'hA5, 1'b0);
    send_raw_byte(8'h5A, 1'b0);
    send_raw_byte(8'h80, 1'b0);
    send_raw_byte(8'h7F, 1'b0);
    send_raw_byte(8'h01, 1'b1);
    // run followed by a literal group at the end
    send_raw_byte(8'h80, 1'b0);
    send_raw_byte(8'h80, 1'b0);
    send_raw_byte(8'h80, 1'b0);
    send_raw_byte(8'h01, 1'b0);
    send_raw_byte(8'hFE, 1'b1);
    send_random_blocks(10);

    // long receiver hold: run past its cap, then a literal group past the buffer size
    drain_outputs();
    holds_asked++;
    repeat (130) send_raw_byte(8'hC3, 1'b0);
    b = 8'hC3;
    for (int i = 0; i < 65; i++) begin
      b = b + 8'h35;
      send_raw_byte(b, i == 64);
    end
    drain_outputs();

    idle_pct = 88;
    send_random_blocks(10);
    idle_pct  = 0;
    stall_pct = 88;
    send_random_blocks(10);
    idle_pct  = 14;
    stall_pct = 14;
    send_random_blocks(10);

    drain_outputs();
    repeat (10) @(posedge clk);
    if (pred.mismatches == 0 && pred.encoded_due.size() == 0) begin
      $display("PASS rle_literal_run_encoder_top");
    end else begin
      $display("FAIL rle_literal_run_encoder_top");
    end
    $finish;
  end

endmodule
